FILE: hw/rtl/mtp_pkg.sv
`default_nettype none

package mtp_pkg;

   localparam int STATE_DEPTH  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int WORD_W       = 32;
   localparam int IDX_W        = $clog2(STATE_DEPTH);
   localparam int MULT_W       = 17;

   localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(STATE_DEPTH - 1);
   localparam logic [IDX_W:0]    FAR_OFFSET = (IDX_W+1)'(TWIST_OFFSET);
   localparam logic [IDX_W:0]    FAR_WRAP   = (IDX_W+1)'(STATE_DEPTH);

   localparam logic [MULT_W-1:0] SEED_MULT  = 17'd69069;
   localparam logic [WORD_W-1:0] SEED_RESET = 32'd4357;
   localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;

   typedef struct packed {
      logic fill_start;
      logic fill_step;
      logic read_issue;
      logic twist_commit;
   } mtp_cmd_type;

   typedef struct packed {
      logic fill_last;
   } mtp_sts_type;

   function automatic logic [WORD_W-1:0] mtp_temper(input logic [WORD_W-1:0] y_in);
      logic [WORD_W-1:0] y;
      y = y_in;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mersenne_twister_prng.sv
`default_nettype none
// Without a refill, a request passes through the READ and TWIST states before the result is registered.
// Each word takes accept, state RAM read, and twist with write-back in turn; no new request is taken until then.
// A held result stalls the twist until it is taken.
// A refill (reseed, or first request after reset) writes all 624 state words, one state word per cycle.
// Reset: synchronous, active high; seed returns to 4357 and the next request refills the state.
// The state RAM has no reset and is never read before it is filled.

module mersenne_twister_prng
   import mtp_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire [7:0]          req_tdata,   // [0] reseed, [7:1] zero
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [WORD_W-1:0]  rsp_tdata,   // [31:0] random_word
   input  wire                csr_wr_en,
   input  wire [WORD_W-1:0]   csr_wr_data
);

   mtp_cmd_type cmd;
   mtp_sts_type sts;

   mtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_reseed(req_tdata[0]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mtp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_word   (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_ram.sv
`default_nettype none

module mtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_dp.sv
`default_nettype none

module mtp_dp
   import mtp_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_wr_en,
   input  wire [WORD_W-1:0]    csr_wr_data,
   input  mtp_cmd_type         cmd,
   output mtp_sts_type         sts,
   output logic [WORD_W-1:0]   rsp_word
);

   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [WORD_W-1:0] fill_word_ff, fill_word_in;
   logic [IDX_W-1:0]  fill_cnt_ff, fill_cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] cur_ff, cur_in;
   logic [WORD_W-1:0] rsp_ff, rsp_in;

   logic [IDX_W-1:0]          nxt_addr;
   logic [IDX_W:0]            far_sum;
   logic [IDX_W-1:0]          far_addr;
   logic [WORD_W+MULT_W-1:0]  fill_prod;
   logic [WORD_W-1:0]         rd_nxt, rd_far;
   logic [WORD_W-1:0]         y;
   logic [WORD_W-1:0]         twisted;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [WORD_W-1:0]         wr_data;

   assign nxt_addr = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
   assign far_sum  = {1'b0, idx_ff} + FAR_OFFSET;
   assign far_addr = (far_sum >= FAR_WRAP) ? IDX_W'(far_sum - FAR_WRAP) : IDX_W'(far_sum);

   assign fill_prod = (WORD_W+MULT_W)'(fill_word_ff) * (WORD_W+MULT_W)'(SEED_MULT);

   // cur_ff holds the pre-twist value of the word at idx_ff
   assign y       = {cur_ff[WORD_W-1], rd_nxt[WORD_W-2:0]};
   assign twisted = rd_far ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);

   always_comb begin
      wr_en   = cmd.fill_step | cmd.twist_commit;
      wr_addr = cmd.fill_step ? fill_cnt_ff : idx_ff;
      wr_data = cmd.fill_step ? fill_word_ff : twisted;
   end

   mtp_ram #(
      .WIDTH(WORD_W),
      .DEPTH(STATE_DEPTH)
   ) u_state_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (cmd.read_issue),
      .rd_addr_a(nxt_addr),
      .rd_addr_b(far_addr),
      .rd_data_a(rd_nxt),
      .rd_data_b(rd_far)
   );

   always_comb begin
      seed_in      = csr_wr_en ? csr_wr_data : seed_ff;
      fill_word_in = fill_word_ff;
      fill_cnt_in  = fill_cnt_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      rsp_in       = rsp_ff;
      if (cmd.fill_start) begin
         fill_word_in = seed_ff;
         fill_cnt_in  = '0;
         idx_in       = '0;
         cur_in       = seed_ff;
      end
      if (cmd.fill_step) begin
         fill_word_in = fill_prod[WORD_W-1:0];
         fill_cnt_in  = (fill_cnt_ff == IDX_LAST) ? '0 : fill_cnt_ff + 1'b1;
      end
      if (cmd.twist_commit) begin
         rsp_in = mtp_temper(twisted);
         cur_in = rd_nxt;
         idx_in = nxt_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff     <= SEED_RESET;
         fill_cnt_ff <= '0;
         idx_ff      <= '0;
      end else begin
         seed_ff     <= seed_in;
         fill_cnt_ff <= fill_cnt_in;
         idx_ff      <= idx_in;
      end
      fill_word_ff <= fill_word_in;
      cur_ff       <= cur_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.fill_last = (fill_cnt_ff == IDX_LAST);
   assign rsp_word      = rsp_ff;

`ifndef ASSERT_OFF
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_LAST)
      else $error("read index out of range");

   a_fill_cnt_range: assert property (@(posedge clock) disable iff (reset)
      fill_cnt_ff <= IDX_LAST)
      else $error("fill counter out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/mtp_ctrl.sv
`default_nettype none

module mtp_ctrl
   import mtp_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire          req_reseed,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output mtp_cmd_type  cmd,
   input  mtp_sts_type  sts
);

   typedef enum logic [1:0] {
      IDLE,
      FILL,
      READ,
      TWIST
   } state_type;

   state_type state_ff, state_in;
   logic      seeded_ff, seeded_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   assign req_tready = (state_ff == IDLE);
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               if (req_reseed || !seeded_ff) begin
                  cmd.fill_start = 1'b1;
                  state_in       = FILL;
               end else begin
                  state_in = READ;
               end
            end
         end
         FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               seeded_in = 1'b1;
               state_in  = READ;
            end
         end
         READ: begin
            cmd.read_issue = 1'b1;
            state_in       = TWIST;
         end
         TWIST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.twist_commit = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.twist_commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   a_seeded_before_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == READ) |-> seeded_ff)
      else $error("state read before fill");

   a_twist_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.read_issue |=> (state_ff == TWIST))
      else $error("read data not consumed");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
   import mtp_pkg::*;

   localparam int MT_N          = 624;
   localparam int MT_M          = 397;
   localparam logic [31:0] MT_MATRIX = 32'h9908_b0df;
   localparam logic [31:0] MT_UPPER  = 32'h8000_0000;
   localparam logic [31:0] MT_LOWER  = 32'h7fff_ffff;
   localparam logic [31:0] MT_MASK_B = 32'h9d2c_5680;
   localparam logic [31:0] MT_MASK_C = 32'hefc6_0000;
   localparam logic [31:0] LCG_MULT  = 32'd69069;
   localparam logic [31:0] SEED_DEFAULT = 32'd4357;
   localparam int QUIET_LIMIT   = 4000;
   localparam int CHUNKS        = 2;
   localparam int CHUNK_ITEMS   = 4;
   localparam int LONG_RUN      = 626;
   localparam int PHASE_ITEMS   = 210;
   localparam int HOLD_CYCLES   = 200;

   typedef enum logic {ROW_REQUEST, ROW_SEED_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic         reseed;
      logic [31:0]  seed;
      logic         fixed;
      logic [31:0]  word;
   } directed_row_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = 8'd0;   // [0] reseed, [7:1] zero
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [WORD_W-1:0] rsp_tdata;            // [31:0] random_word
   logic              csr_wr_en   = 1'b0;
   logic [WORD_W-1:0] csr_wr_data = '0;

   logic [31:0] mt_state [MT_N];
   int          mt_index  = MT_N;
   logic        mt_seeded = 1'b0;
   logic [31:0] seed_reg  = SEED_DEFAULT;

   logic [31:0] pending_words [$];
   logic [31:0] expected_word;
   int          error_count   = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 29;
   int          rcv_idle_pct  = 45;
   int          hold_request  = 0;
   int          hold_left     = 0;

   directed_row_type directed_rows [21] = '{
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0}, // first request refills anyway
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0},
      '{ROW_SEED_WRITE, 1'b0, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0}, // old state still in use
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b1, 32'd0}, // zero seed: all-zero words
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b1, 32'd0},
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b1, 32'd0},
      '{ROW_SEED_WRITE, 1'b0, 32'hffff_ffff, 1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0},
      '{ROW_SEED_WRITE, 1'b0, 32'd1,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0}, // back-to-back reseeds
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0},
      '{ROW_SEED_WRITE, 1'b0, 32'd4357,      1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0},
      '{ROW_SEED_WRITE, 1'b0, 32'h8000_0000, 1'b0, 32'd0},
      '{ROW_REQUEST,    1'b1, 32'd0,         1'b0, 32'd0},
      '{ROW_REQUEST,    1'b0, 32'd0,         1'b0, 32'd0}
   };

   mersenne_twister_prng dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void refill_state();
      mt_state[0] = seed_reg;
      for (int k = 1; k < MT_N; k++) mt_state[k] = LCG_MULT * mt_state[k-1];
      mt_index  = MT_N;
      mt_seeded = 1'b1;
   endfunction

   function automatic void twist_state();
      logic [31:0] y;
      logic [31:0] v;
      for (int k = 0; k < MT_N; k++) begin
         y = (mt_state[k] & MT_UPPER) | (mt_state[(k + 1) % MT_N] & MT_LOWER);
         v = mt_state[(k + MT_M) % MT_N] ^ (y >> 1);
         if (y[0]) v = v ^ MT_MATRIX;
         mt_state[k] = v;
      end
      mt_index = 0;
   endfunction

   function automatic logic [31:0] temper_word(input logic [31:0] raw);
      logic [31:0] y;
      y = raw;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_MASK_B);
      y = y ^ ((y << 15) & MT_MASK_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic logic [31:0] predict_word(input logic reseed);
      logic [31:0] w;
      if (reseed || !mt_seeded) refill_state();
      if (mt_index >= MT_N) twist_state();
      w = temper_word(mt_state[mt_index]);
      mt_index++;
      return w;
   endfunction

   // returns at the posedge where the request is taken
   task automatic push_request(input logic reseed, input logic fixed,
                               input logic [31:0] fixed_word);
      logic [31:0] w;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      w = predict_word(reseed);
      pending_words.push_back(fixed ? fixed_word : w);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, reseed};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      wait_for_drain();
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      seed_reg = value;
   endtask

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: return SEED_DEFAULT;
         default: return $urandom;
      endcase
   endfunction

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: random_word expected none, got %h", $time, rsp_tdata);
            error_count++;
         end else begin
            expected_word = pending_words.pop_front();
            if (rsp_tdata !== expected_word) begin
               $display("%0t: random_word expected %h, got %h",
                        $time, expected_word, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("mersenne_twister_prng verification failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SEED_WRITE) begin
            write_seed(directed_rows[i].seed);
         end else begin
            push_request(directed_rows[i].reseed, directed_rows[i].fixed,
                         directed_rows[i].word);
         end
      end

      for (int phase = 0; phase < 2; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 45;
            rcv_idle_pct  = 29;
         end
         for (int c = 0; c < CHUNKS; c++) begin
            write_seed(pick_seed());
            push_request(1'($urandom_range(1)), 1'b0, 32'd0);
            for (int n = 1; n < CHUNK_ITEMS; n++) begin
               push_request($urandom_range(99) < 4, 1'b0, 32'd0);
            end
         end
      end

      // long run with no reseed after its first request, so the state is twisted again mid-stream
      send_idle_pct = 29;
      rcv_idle_pct  = 45;
      write_seed($urandom);
      push_request(1'b1, 1'b0, 32'd0);
      for (int n = 1; n < LONG_RUN; n++) begin
         if (n == PHASE_ITEMS) begin
            send_idle_pct = 45;
            rcv_idle_pct  = 29;
         end
         if (n == 2 * PHASE_ITEMS) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
            hold_request  = HOLD_CYCLES;
         end
         push_request(1'b0, 1'b0, 32'd0);
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("mersenne_twister_prng verification clean");
      end else begin
         $display("mersenne_twister_prng verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
